### rtl/core/kabf_pkg.sv
// Package for the angle and gyro bias Kalman filter.
// Holds fixed-point constants, register indices, reset defaults and the sat32 saturation helper.
package kabf_pkg;

    localparam int unsigned W = 32;
    localparam logic signed [W-1:0] DEG_90 = 32'sd5898240;
    localparam logic signed [W-1:0] DEG_180 = 32'sd11796480;
    localparam logic signed [W+1:0] DEG_360 = 34'sd23592960;

    localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE = 2'd2;
    localparam logic [1:0] REG_NEGATE = 2'd3;

    localparam logic [W-1:0] RST_ANGLE_NOISE = 32'd83886;
    localparam logic [W-1:0] RST_BIAS_NOISE = 32'd150995;
    localparam logic [W-1:0] RST_MEAS_NOISE = 32'd8389;

    function automatic logic signed [W-1:0] sat32(input logic signed [66:0] v);
        logic signed [W-1:0] r;
        r = v[W-1:0];
        if (v > 67'sh7FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -67'sh80000000) begin
            r = 32'sh80000000;
        end
        return r;
    endfunction

endpackage

### rtl/core/kabf_mul.sv
// Shared multiplier with half-up rounding shift for the Kalman filter.
// Depends on kabf_pkg.
module kabf_mul (
    input  logic                            i_clk,
    input  logic signed [kabf_pkg::W:0]     i_a,
    input  logic signed [kabf_pkg::W:0]     i_b,
    input  logic                            i_q24,
    output logic signed [66:0]              o_p
);
    import kabf_pkg::*;

    logic signed [65:0] r_prod;
    logic               r_q24;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_q24 <= i_q24;
    end

    always_comb begin
        if (r_q24) begin
            o_p = 67'(r_prod + 66'sd8388608) >>> 24;
        end else begin
            o_p = 67'(r_prod + 66'sd32768) >>> 16;
        end
    end
endmodule

### rtl/core/kabf_div.sv
// Restoring divider, one quotient bit per cycle, for the Kalman gains.
// Computes sat32((n * 2^24) / d) truncated toward zero; zero when d is zero.
// Depends on kabf_pkg.
module kabf_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [31:0]   i_num,
    input  logic signed [33:0]   i_den,
    output logic                 o_done,
    output logic signed [31:0]   o_quo
);
    import kabf_pkg::*;

    logic [55:0] r_n;
    logic [33:0] r_d;
    logic [56:0] r_q;
    logic [34:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_neg;
    logic        r_zero;
    logic [34:0] trial;

    assign trial = {r_rem[33:0], r_n[55]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && !i_start && (r_cnt == 6'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'd56;
                r_n <= 56'(i_num[31] ? -(57'(i_num)) : 57'(i_num)) << 24;
                r_d <= i_den[33] ? 34'(-i_den) : i_den;
                r_neg <= i_num[31] ^ i_den[33];
                r_zero <= (i_den == '0);
                r_rem <= '0;
                r_q <= '0;
            end else if (r_busy) begin
                if (trial >= {1'b0, r_d}) begin
                    r_rem <= trial - {1'b0, r_d};
                    r_q <= {r_q[55:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_q <= {r_q[55:0], 1'b0};
                end
                r_n <= {r_n[54:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quo = '0;
        end else if (r_neg) begin
            o_quo = sat32(-(67'(r_q)));
        end else begin
            o_quo = sat32(67'(r_q));
        end
    end
endmodule

### rtl/core/kalman_angle_bias_filter.sv
// Two-state Kalman filter for tilt angle and gyro bias, fixed point.
// Channels: input request (measured angle, gyro rate, time step) and output
// request (filtered angle, bias), both valid/ready, plus a register write
// channel (index, data) for the three noise values and the negate flag.
// One shared 33x33 multiplier and a one-bit-per-cycle divider do all math
// under a sequencer. The angle is wrapped by one 360-degree fold per step
// (at most 91 folds) before it goes to the output register.
// The two 56-step gain divisions run one after the other. A new request
// is taken in the cycle after the result is handed to the output register,
// so no request is taken while the last one is still being computed.
// A snap case (estimate and measurement on opposite sides beyond 90 degrees)
// skips the filter math and goes through the wrap step to the output register.
// The result waits in an output register. While it waits, the next request
// can be accepted and computed; that request then holds until the receiver
// takes the waiting result.
// Reset clears the estimate, bias and covariance to zero, empties the
// output register and loads the noise registers with their defaults.
// Register writes are taken at any time and should only occur when idle.
module kalman_angle_bias_filter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [24:0]   i_measured_angle,
    input  logic signed [27:0]   i_gyro_rate,
    input  logic [19:0]          i_time_step,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [24:0]   o_filtered_angle,
    output logic signed [31:0]   o_bias_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import kabf_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b00000001,
        ST_MUL  = 8'b00000010,
        ST_WAIT = 8'b00000100,
        ST_DIVA = 8'b00001000,
        ST_DIVB = 8'b00010000,
        ST_WRAP = 8'b00100000,
        ST_OUT  = 8'b01000000,
        ST_DDIV = 8'b10000000
    } t_state;

    t_state r_state;
    logic [31:0] r_qa, r_qb, r_rm;
    logic        r_neg;
    logic signed [31:0] r_ang, r_bias, r_aa, r_ab, r_ba, r_bb;
    logic signed [31:0] r_meas, r_dt;
    logic signed [31:0] r_rate, r_t, r_p00, r_p01, r_p10, r_p11, r_ka, r_kb, r_y;
    logic signed [31:0] r_pang;
    logic [3:0]  r_step;
    logic signed [33:0] r_wr;
    logic signed [24:0] r_out_ang;
    logic signed [31:0] r_out_bias;
    logic               r_out_valid;
    logic               out_load;

    logic signed [32:0] mul_a, mul_b;
    logic               mul_q24;
    logic signed [66:0] prod;
    logic               div_start, div_done;
    logic signed [31:0] div_num, div_quo;
    logic signed [33:0] s_val;

    kabf_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .i_q24(mul_q24), .o_p(prod));
    kabf_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
                    .i_den(s_val), .o_done(div_done), .o_quo(div_quo));

    assign s_val = 34'(r_p00) + 34'({1'b0, r_rm});
    assign o_ready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid = r_out_valid;
    assign o_filtered_angle = r_out_ang;
    assign o_bias_out = r_out_bias;
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || i_ready);

    always_comb begin
        mul_q24 = 1'b0;
        mul_a = 33'(r_dt);
        mul_b = 33'(r_rate);
        unique case (r_step)
            4'd0: mul_b = 33'(r_rate);
            4'd1: mul_b = 33'(r_bb);
            4'd2: mul_b = 33'(r_t);
            4'd3: mul_b = {1'b0, r_qb};
            4'd4: begin mul_q24 = 1'b1; mul_a = 33'(r_ka); mul_b = 33'(r_y); end
            4'd5: begin mul_q24 = 1'b1; mul_a = 33'(r_kb); mul_b = 33'(r_y); end
            4'd6: begin mul_q24 = 1'b1; mul_a = 33'(r_ka); mul_b = 33'(r_p00); end
            4'd7: begin mul_q24 = 1'b1; mul_a = 33'(r_ka); mul_b = 33'(r_p01); end
            4'd8: begin mul_q24 = 1'b1; mul_a = 33'(r_kb); mul_b = 33'(r_p00); end
            default: begin mul_q24 = 1'b1; mul_a = 33'(r_kb); mul_b = 33'(r_p01); end
        endcase
    end

    assign div_start = (r_state == ST_DDIV);
    assign div_num = (r_step == 4'd0) ? r_p00 : r_p10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= RST_ANGLE_NOISE;
            r_qb <= RST_BIAS_NOISE;
            r_rm <= RST_MEAS_NOISE;
            r_neg <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ANGLE_NOISE: r_qa <= i_cfg_data;
                REG_BIAS_NOISE:  r_qb <= i_cfg_data;
                REG_MEAS_NOISE:  r_rm <= i_cfg_data;
                REG_NEGATE:      r_neg <= i_cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ang <= 25'(r_ang);
            r_out_bias <= r_bias;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step <= '0;
            r_ang <= '0; r_bias <= '0;
            r_aa <= '0; r_ab <= '0; r_ba <= '0; r_bb <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: if (i_valid) begin
                    r_meas <= 32'(i_measured_angle);
                    r_dt <= {12'd0, i_time_step};
                    r_pang <= r_ang;
                    r_step <= '0;
                    if ((32'(i_measured_angle) < -DEG_90 && r_ang > DEG_90) ||
                        (32'(i_measured_angle) > DEG_90 && r_ang < -DEG_90)) begin
                        r_wr <= 34'(i_measured_angle);
                        r_state <= ST_WRAP;
                    end else begin
                        r_rate <= sat32(67'(((r_neg && (r_ang > DEG_90 || r_ang < -DEG_90)) ?
                                  -33'(i_gyro_rate) : 33'(i_gyro_rate))) - 67'(r_bias));
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (r_step == 4'd3) begin
                        r_step <= 4'd0;
                        r_state <= ST_DDIV;
                    end else if (r_step >= 4'd9) begin
                        r_state <= ST_WRAP;
                    end else begin
                        r_step <= r_step + 4'd1;
                        r_state <= ST_MUL;
                    end
                    unique case (r_step)
                        4'd0: r_pang <= sat32(67'(r_ang) + prod);
                        4'd1: begin
                            r_t <= sat32(prod - 67'(r_ab) - 67'(r_ba) + 67'({1'b0, r_qa}));
                            r_p01 <= sat32(67'(r_ab) - prod);
                            r_p10 <= sat32(67'(r_ba) - prod);
                        end
                        4'd2: r_p00 <= sat32(67'(r_aa) + prod);
                        4'd3: begin
                            r_p11 <= sat32(67'(r_bb) + prod);
                            r_y <= sat32(67'(r_meas) - 67'(r_pang));
                        end
                        4'd4: r_pang <= sat32(67'(r_pang) + prod);
                        4'd5: r_bias <= sat32(67'(r_bias) + prod);
                        4'd6: r_aa <= sat32(67'(r_p00) - prod);
                        4'd7: r_ab <= sat32(67'(r_p01) - prod);
                        4'd8: r_ba <= sat32(67'(r_p10) - prod);
                        default: begin
                            r_bb <= sat32(67'(r_p11) - prod);
                            r_wr <= 34'(r_pang);
                        end
                    endcase
                end
                ST_DDIV: r_state <= (r_step == 4'd0) ? ST_DIVA : ST_DIVB;
                ST_DIVA: if (div_done) begin
                    r_ka <= div_quo;
                    r_step <= 4'd1;
                    r_state <= ST_DDIV;
                end
                ST_DIVB: if (div_done) begin
                    r_kb <= div_quo;
                    r_step <= 4'd4;
                    r_state <= ST_MUL;
                end
                ST_WRAP: begin
                    if (r_wr > 34'(DEG_180)) begin
                        r_wr <= r_wr - DEG_360;
                    end else if (r_wr < -34'(DEG_180)) begin
                        r_wr <= r_wr + DEG_360;
                    end else begin
                        r_ang <= 32'(r_wr);
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: if (out_load) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

### dv/kalman_angle_bias_filter_tb.sv
// Self-checking testbench for the angle and gyro bias Kalman filter.
// A queue-fed driver and a clocked monitor check every result against a built-in
// fixed-point filter predictor. Depends on kabf_pkg and kalman_angle_bias_filter.
`timescale 1ns / 1ps

module kalman_angle_bias_filter_tb;
    import kabf_pkg::*;

    typedef struct {
        logic signed [24:0] ang;
        logic signed [27:0] gyro;
        logic [19:0]        dt;
    } t_sample;

    typedef struct {
        logic signed [24:0] ang;
        logic signed [31:0] bias;
    } t_filt;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic signed [24:0]  i_measured_angle;
    logic signed [27:0]  i_gyro_rate;
    logic [19:0]         i_time_step;
    logic                o_valid;
    logic                i_ready;
    logic signed [24:0]  o_filtered_angle;
    logic signed [31:0]  o_bias_out;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index;
    logic [31:0]         i_cfg_data;

    kalman_angle_bias_filter uut (.*);

    t_sample pending_q[$];
    t_filt   filt_expect_q[$];
    t_sample cur_sample;
    int      errors;
    int      tx_gap;
    int      rx_stall;
    int      rx_hold_left;
    bit      rx_hold_req;

    longint q_angle, q_bias, r_meas;
    bit     neg_cfg;
    longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint clamp_q(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint rnd_shift(longint a, longint b, int n);
        return (a * b + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint wrap_deg(longint a);
        longint r;
        r = a % longint'(DEG_360);
        if (r > longint'(DEG_180)) r -= longint'(DEG_360);
        if (r < -longint'(DEG_180)) r += longint'(DEG_360);
        return r;
    endfunction

    function automatic longint gain_q24(longint c, longint s);
        if (s == 0) return 0;
        return clamp_q((c * 64'sd16777216) / s);
    endfunction

    function automatic t_filt kalman_step(t_sample s);
        longint meas, gyro, dt, prev, rate, ang, dtbb, t;
        longint p00, p01, p10, p11, sv, ka, kb, y;
        t_filt r;
        meas = longint'(s.ang);
        gyro = longint'(s.gyro);
        dt = longint'(s.dt);
        prev = est_angle;
        if (neg_cfg && (prev > longint'(DEG_90) || prev < -longint'(DEG_90))) gyro = -gyro;
        if ((meas < -longint'(DEG_90) && prev > longint'(DEG_90)) ||
            (meas > longint'(DEG_90) && prev < -longint'(DEG_90))) begin
            est_angle = wrap_deg(meas);
        end else begin
            rate = clamp_q(gyro - est_bias);
            ang = clamp_q(est_angle + rnd_shift(dt, rate, 16));
            dtbb = rnd_shift(dt, p_bb, 16);
            t = clamp_q(dtbb - p_ab - p_ba + q_angle);
            p00 = clamp_q(p_aa + rnd_shift(dt, t, 16));
            p01 = clamp_q(p_ab - dtbb);
            p10 = clamp_q(p_ba - dtbb);
            p11 = clamp_q(p_bb + rnd_shift(q_bias, dt, 16));
            sv = p00 + r_meas;
            ka = gain_q24(p00, sv);
            kb = gain_q24(p10, sv);
            y = clamp_q(meas - ang);
            ang = clamp_q(ang + rnd_shift(ka, y, 24));
            est_bias = clamp_q(est_bias + rnd_shift(kb, y, 24));
            p_aa = clamp_q(p00 - rnd_shift(ka, p00, 24));
            p_ab = clamp_q(p01 - rnd_shift(ka, p01, 24));
            p_ba = clamp_q(p10 - rnd_shift(kb, p00, 24));
            p_bb = clamp_q(p11 - rnd_shift(kb, p01, 24));
            est_angle = wrap_deg(ang);
        end
        r.ang = est_angle[24:0];
        r.bias = est_bias[31:0];
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s mismatch: got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Request driver: the predictor runs on each accepted request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_valid && o_ready) filt_expect_q.push_back(kalman_step(cur_sample));
            if (i_valid && !o_ready) begin
                i_valid <= 1'b1;
            end else if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                cur_sample = pending_q.pop_front();
                i_measured_angle <= cur_sample.ang;
                i_gyro_rate <= cur_sample.gyro;
                i_time_step <= cur_sample.dt;
                i_valid <= 1'b1;
                tx_gap = pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_filt want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_stall = 0;
            rx_hold_left = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (filt_expect_q.size() == 0) begin
                    $display("%0t: result with no request outstanding", $time);
                    errors++;
                end else begin
                    want = filt_expect_q.pop_front();
                    if (o_filtered_angle !== want.ang)
                        report_mismatch("filtered_angle", o_filtered_angle, want.ang);
                    if (o_bias_out !== want.bias)
                        report_mismatch("bias_out", o_bias_out, want.bias);
                end
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_hold_left = 3000;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                rx_stall = pick_gap();
            end
        end
    end

    task automatic load_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_ANGLE_NOISE: q_angle = longint'(val);
            REG_BIAS_NOISE:  q_bias = longint'(val);
            REG_MEAS_NOISE:  r_meas = longint'(val);
            REG_NEGATE:      neg_cfg = val[0];
        endcase
    endtask

    task automatic add_sample(int a, int g, int d);
        t_sample s;
        s.ang = 25'(a);
        s.gyro = 28'(g);
        s.dt = 20'(d);
        pending_q.push_back(s);
    endtask

    task automatic add_random(int n);
        int k;
        repeat (n) begin
            k = $urandom_range(0, 19);
            if (k < 14)
                add_sample(int'($urandom_range(0, 23592960)) - 11796480,
                           int'($urandom_range(0, 262144000)) - 131072000,
                           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1048575)
                                                       : $urandom_range(0, 3000));
            else if (k < 17)
                add_sample($urandom, $urandom, $urandom);
            else
                add_sample(($urandom_range(0, 1) != 0) ? 11796480 : -11796480,
                           ($urandom_range(0, 1) != 0) ? 131072000 : -131072000,
                           ($urandom_range(0, 1) != 0) ? 1048575 : 0);
        end
    endtask

    task automatic drain();
        do @(negedge i_clk); while (pending_q.size() != 0 || i_valid ||
                                     filt_expect_q.size() != 0);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        errors = 0;
        rx_hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_measured_angle = '0;
        i_gyro_rate = '0;
        i_time_step = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_ANGLE_NOISE;
        i_cfg_data = '0;
        q_angle = longint'(RST_ANGLE_NOISE);
        q_bias = longint'(RST_BIAS_NOISE);
        r_meas = longint'(RST_MEAS_NOISE);
        neg_cfg = 1'b0;
        est_angle = 0; est_bias = 0;
        p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        add_sample(0, 0, 0);
        add_sample(11796480, 131072000, 1048575);
        add_sample(-11796480, -131072000, 1048575);
        add_sample(-1, -1, 1);
        add_sample(25'h0FFFFFF, 28'h7FFFFFF, 20'hFFFFF);
        add_sample(25'h1000000, 28'h8000000, 20'h80000);
        add_sample(11796480, 0, 65536);
        // Pull the estimate past 90 degrees, then cross over to force a snap.
        repeat (4) add_sample(170 * 65536, 0, 1000);
        add_sample(-170 * 65536, 0, 1000);
        add_sample(170 * 65536, 1000, 1000);
        add_sample(-11796480, 0, 500);
        add_random(300);
        drain();

        // Zero noise with the negate flag set: the innovation variance collapses to zero.
        load_reg(REG_MEAS_NOISE, 32'd0);
        load_reg(REG_ANGLE_NOISE, 32'd0);
        load_reg(REG_BIAS_NOISE, 32'd0);
        load_reg(REG_NEGATE, 32'd1);
        @(negedge i_clk);
        repeat (4) add_sample(5 * 65536, 100, 0);
        repeat (3) add_sample(120 * 65536, 30 * 65536, 0);
        add_sample(-120 * 65536, 65536, 0);
        add_random(300);
        drain();

        load_reg(REG_MEAS_NOISE, 32'hFFFFFFFF);
        load_reg(REG_ANGLE_NOISE, 32'hFFFFFFFF);
        load_reg(REG_BIAS_NOISE, 32'hFFFFFFFF);
        @(negedge i_clk);
        add_random(300);
        rx_hold_req = 1'b1;
        drain();

        load_reg(REG_MEAS_NOISE, RST_MEAS_NOISE);
        load_reg(REG_ANGLE_NOISE, RST_ANGLE_NOISE);
        load_reg(REG_BIAS_NOISE, RST_BIAS_NOISE);
        load_reg(REG_NEGATE, 32'd0);
        @(negedge i_clk);
        add_random(300);
        drain();

        repeat (2) begin
            load_reg(REG_MEAS_NOISE, ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65536)
                                                                 : $urandom);
            load_reg(REG_ANGLE_NOISE, ($urandom_range(0, 1) != 0) ? $urandom_range(0, 1 << 20)
                                                                  : $urandom);
            load_reg(REG_BIAS_NOISE, ($urandom_range(0, 1) != 0) ? $urandom_range(0, 1 << 20)
                                                                 : $urandom);
            load_reg(REG_NEGATE, $urandom_range(0, 1));
            @(negedge i_clk);
            add_random(300);
            drain();
        end

        if (errors == 0) begin
            $display("kalman_angle_bias_filter_tb OK");
        end else begin
            $display("kalman_angle_bias_filter_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("%0t: timeout", $time);
        $display("kalman_angle_bias_filter_tb NOT OK");
        $finish;
    end

endmodule
